// ----- hw/rtl/csoc_pkg.sv -----
// shared types, codes and fixed-point constants of the current sense offset calibration
package csoc_pkg;

  localparam int unsigned CodeW  = 12;
  localparam int unsigned CountW = 16;
  localparam int unsigned SumW   = 28;
  localparam int unsigned UvW    = 22;
  localparam int unsigned OffW   = 23;
  localparam int unsigned CurW   = 21;
  localparam int unsigned MvW    = 13;
  localparam int unsigned CfgW   = 16;

  // floor(code * 3300000 / 4095) = code * 805 + floor(code * 235 / 273)
  localparam logic [19:0] UvWhole   = 20'd805;
  localparam logic [19:0] UvFracNum = 20'd235;
  localparam logic [40:0] RecipFrac = 41'd1966561;   // ceil(2^29 / 273)
  localparam int unsigned FracShift = 29;
  localparam logic [60:0] RecipMa   = 61'd1099511628; // ceil(2^40 / 1000)
  localparam int unsigned MaShift   = 40;
  localparam logic [44:0] RecipMv   = 45'd4294968;    // ceil(2^32 / 1000)
  localparam int unsigned MvShift   = 32;
  localparam logic [21:0] UvPerMv   = 22'd1000;

  localparam logic [CurW:0] CurMaxMag = 22'd1048575;
  localparam logic [CurW:0] CurMinMag = 22'd1048576;

  localparam logic [21:0] RefUvReset = 22'd1650000;
  localparam logic [6:0]  ApvReset   = 7'd20;
  localparam logic [15:0] NReset     = 16'd1;
  localparam logic [15:0] DelayReset = 16'd10;

  localparam logic [4:0] DivLast = 5'd27;

  typedef enum logic [1:0] {
    CFG_ZERO_REF  = 2'd0,
    CFG_GAIN      = 2'd1,
    CFG_SAMPLES   = 2'd2,
    CFG_DELAY     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_SAMPLE = 2'd0,
    ACT_TICK   = 2'd1,
    ACT_CAL    = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_NONE  = 2'd0,
    ST_DONE  = 2'd1,
    ST_ABORT = 2'd2
  } cal_status_e;

  typedef struct packed {
    logic [UvW-1:0]    ref_uv;
    logic [6:0]        apv;
    logic [CountW-1:0] n;
    logic [CountW-1:0] delay;
  } cfg_t;

  typedef struct packed {
    logic sample;
    logic clr;
    logic acc;
    logic finish;
  } lane_cmd_t;

  typedef struct packed {
    logic        busy;
    cal_status_e status;
  } cal_res_t;

endpackage

// ----- hw/rtl/csoc_ctrl.sv -----
// calibration sequencer: delay count, averaging count and per-request lane commands
module csoc_ctrl import csoc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       action_i,
  input  logic [CodeW-1:0] raw_u_i,
  input  logic [CodeW-1:0] raw_v_i,
  input  cfg_t             cfg_i,
  output lane_cmd_t        cmd_o,
  output cal_res_t         res_o
);

  logic              waiting_q, waiting_d;
  logic              averaging_q, averaging_d;
  logic [CountW-1:0] elapsed_q, elapsed_d;
  logic [CountW-1:0] taken_q, taken_d;

  always_comb begin
    logic              avg;
    logic              fresh;
    logic [CountW:0]   taken_nx;
    avg         = averaging_q;
    fresh       = 1'b0;
    taken_nx    = '0;
    waiting_d   = waiting_q;
    averaging_d = averaging_q;
    elapsed_d   = elapsed_q;
    taken_d     = taken_q;
    cmd_o       = '0;
    res_o.status = ST_NONE;
    if (accept_i) begin
      unique case (act_e'(action_i))
        ACT_CAL: begin
          waiting_d   = 1'b1;
          averaging_d = 1'b0;
          elapsed_d   = '0;
          taken_d     = '0;
          cmd_o.clr   = 1'b1;
        end
        ACT_TICK: begin
          if (waiting_q && (elapsed_q != {CountW{1'b1}})) begin
            elapsed_d = elapsed_q + 1'b1;
          end
        end
        ACT_SAMPLE: begin
          cmd_o.sample = 1'b1;
          if (waiting_q && (elapsed_q >= cfg_i.delay)) begin
            waiting_d = 1'b0;
            if ((raw_u_i == '0) && (raw_v_i == '0)) begin
              res_o.status = ST_ABORT;
            end else begin
              avg       = 1'b1;
              fresh     = 1'b1;
              cmd_o.clr = 1'b1;
            end
          end
          if (avg) begin
            cmd_o.acc = 1'b1;
            taken_nx  = {1'b0, (fresh ? {CountW{1'b0}} : taken_q)} + 1'b1;
            if (taken_nx >= {1'b0, cfg_i.n}) begin
              cmd_o.finish = 1'b1;
              averaging_d  = 1'b0;
              taken_d      = '0;
              res_o.status = ST_DONE;
            end else begin
              averaging_d = 1'b1;
              taken_d     = taken_nx[CountW-1:0];
            end
          end
        end
        default: ;
      endcase
    end
    res_o.busy = waiting_d | averaging_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q   <= 1'b0;
      averaging_q <= 1'b0;
      elapsed_q   <= '0;
      taken_q     <= '0;
    end else begin
      waiting_q   <= waiting_d;
      averaging_q <= averaging_d;
      elapsed_q   <= elapsed_d;
      taken_q     <= taken_d;
    end
  end

endmodule

// ----- hw/rtl/csoc_lane.sv -----
// one phase lane: code to current conversion, sample sum, mean divide and offset update
module csoc_lane import csoc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  lane_cmd_t              cmd_i,
  input  logic [CodeW-1:0]       code_i,
  input  cfg_t                   cfg_i,
  input  logic                   ack_i,
  output logic                   done_o,
  output logic signed [CurW-1:0] current_o,
  output logic signed [MvW-1:0]  offset_mv_o
);

  typedef enum logic [10:0] {
    L_IDLE  = 11'b00000000001,
    L_CONV1 = 11'b00000000010,
    L_CONV2 = 11'b00000000100,
    L_MUL   = 11'b00000001000,
    L_RCP   = 11'b00000010000,
    L_SAT   = 11'b00000100000,
    L_DIV   = 11'b00001000000,
    L_OFS   = 11'b00010000000,
    L_OMV1  = 11'b00100000000,
    L_OMV2  = 11'b01000000000,
    L_DONE  = 11'b10000000000
  } lane_state_e;

  lane_state_e state_q, state_d;
  logic        mean_q, finish_q;
  logic [4:0]  cnt_q;

  logic [SumW-1:0]          sum_q, sum_d;
  logic signed [OffW-1:0]   off_q;
  logic signed [CurW-1:0]   cur_q;
  logic signed [MvW-1:0]    omv_q;

  logic [CodeW-1:0]  code_q;
  logic [SumW-1:0]   dq_q;
  logic [CountW-1:0] rem_q;
  logic [19:0]       y_q;
  logic [UvW-1:0]    base_q, uv_q;
  logic signed [31:0] p_q;
  logic              neg_q;
  logic [CurW-1:0]   mag_q;
  logic              oneg_q;
  logic [CodeW-1:0]  omag_q;

  logic [CodeW-1:0]  conv_code;
  logic [40:0]       frac_prod;
  logic signed [24:0] v_s;
  logic signed [31:0] p_d;
  logic [31:0]       p_abs;
  logic [60:0]       ma_prod;
  logic signed [CurW:0] cur_s;
  logic signed [CurW-1:0] cur_d;
  logic [CountW:0]   trial;
  logic              ge;
  logic signed [OffW-1:0] off_d;
  logic [OffW-1:0]   off_abs;
  logic [44:0]       mv_prod;

  assign conv_code = mean_q ? dq_q[CodeW-1:0] : code_q;
  assign sum_d     = (cmd_i.clr ? {SumW{1'b0}} : sum_q)
                   + (cmd_i.acc ? {{(SumW-CodeW){1'b0}}, code_i} : {SumW{1'b0}});
  assign frac_prod = {21'b0, y_q} * RecipFrac;
  assign v_s       = $signed({3'b0, uv_q}) + 25'(off_q) - $signed({3'b0, cfg_i.ref_uv});
  assign p_d       = 32'(v_s) * 32'($signed({1'b0, cfg_i.apv}));
  assign p_abs     = p_q[31] ? 32'(-p_q) : 32'(p_q);
  assign ma_prod   = {31'b0, p_abs[29:0]} * RecipMa;
  assign cur_s     = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  assign trial     = {rem_q, dq_q[SumW-1]};
  assign ge        = trial >= {1'b0, cfg_i.n};
  assign off_d     = $signed({1'b0, cfg_i.ref_uv}) - $signed({1'b0, uv_q});
  assign off_abs   = off_q[OffW-1] ? OffW'(-off_q) : OffW'(off_q);
  assign mv_prod   = {23'b0, off_abs[UvW-1:0]} * RecipMv;

  always_comb begin
    if (!neg_q && ({1'b0, mag_q} > CurMaxMag)) begin
      cur_d = {1'b0, {(CurW-1){1'b1}}};
    end else if (neg_q && ({1'b0, mag_q} > CurMinMag)) begin
      cur_d = {1'b1, {(CurW-1){1'b0}}};
    end else begin
      cur_d = cur_s[CurW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE:  if (start_i) state_d = cmd_i.sample ? L_CONV1 : L_DONE;
      L_CONV1: state_d = L_CONV2;
      L_CONV2: state_d = mean_q ? L_OFS : L_MUL;
      L_MUL:   state_d = L_RCP;
      L_RCP:   state_d = L_SAT;
      L_SAT:   state_d = finish_q ? L_DIV : L_DONE;
      L_DIV:   if (cnt_q == DivLast) state_d = L_CONV1;
      L_OFS:   state_d = L_OMV1;
      L_OMV1:  state_d = L_OMV2;
      L_OMV2:  state_d = L_DONE;
      L_DONE:  if (ack_i) state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= L_IDLE;
      mean_q   <= 1'b0;
      finish_q <= 1'b0;
      cnt_q    <= '0;
      sum_q    <= '0;
      off_q    <= '0;
      cur_q    <= '0;
      omv_q    <= '0;
    end else begin
      state_q <= state_d;
      if ((state_q == L_IDLE) && start_i) begin
        mean_q   <= 1'b0;
        finish_q <= cmd_i.finish;
        cnt_q    <= '0;
        sum_q    <= cmd_i.finish ? {SumW{1'b0}} : sum_d;
      end
      if (state_q == L_SAT) cur_q <= cur_d;
      if (state_q == L_DIV) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DivLast) mean_q <= 1'b1;
      end
      if (state_q == L_OFS) off_q <= off_d;
      if (state_q == L_OMV2) begin
        omv_q <= oneg_q ? -$signed({1'b0, omag_q}) : $signed({1'b0, omag_q});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == L_IDLE) && start_i) begin
      code_q <= code_i;
      dq_q   <= sum_d;
      rem_q  <= '0;
    end
    if (state_q == L_CONV1) begin
      y_q    <= {8'b0, conv_code} * UvFracNum;
      base_q <= {10'b0, conv_code} * UvW'(UvWhole);
    end
    if (state_q == L_CONV2) uv_q <= base_q + {10'b0, frac_prod[FracShift+CodeW-1:FracShift]};
    if (state_q == L_MUL) p_q <= p_d;
    if (state_q == L_RCP) begin
      neg_q <= p_q[31];
      mag_q <= ma_prod[MaShift+CurW-1:MaShift];
    end
    if (state_q == L_DIV) begin
      rem_q <= ge ? CountW'(trial - {1'b0, cfg_i.n}) : trial[CountW-1:0];
      dq_q  <= {dq_q[SumW-2:0], ge};
    end
    if (state_q == L_OMV1) begin
      oneg_q <= off_q[OffW-1];
      omag_q <= mv_prod[MvShift+CodeW-1:MvShift];
    end
  end

  assign done_o      = (state_q == L_DONE);
  assign current_o   = cur_q;
  assign offset_mv_o = omv_q;

endmodule

// ----- hw/rtl/current_sense_offset_calibration.sv -----
// top level: configuration registers, calibration sequencer, two phase lanes, result merge
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_stall_o   action_i, raw_u_i, raw_v_i
//  out       source     out_valid_o / out_stall_i current u/v, offset u/v, cal_busy, cal_status
//  cfg       sink       cfg_we_i                  cfg_idx_i, cfg_data_i
//
// tick, calibrate and unused requests skip the lane maths, a sample converts and saturates
// the sample that ends a calibration adds the 28-step mean divide and the offset update
// one request at a time goes through the lanes; in_stall_o is high from accept to result load
// a finished result waits in the output register while the next request is accepted
// reset clears the calibration state, offsets and last currents and loads register defaults
module current_sense_offset_calibration import csoc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             action_i,
  input  logic [CodeW-1:0]       raw_u_i,
  input  logic [CodeW-1:0]       raw_v_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [CurW-1:0] current_u_ma_o,
  output logic signed [CurW-1:0] current_v_ma_o,
  output logic signed [MvW-1:0]  offset_u_mv_o,
  output logic signed [MvW-1:0]  offset_v_mv_o,
  output logic                   cal_busy_o,
  output logic [1:0]             cal_status_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CfgW-1:0]        cfg_data_i
);

  cfg_t      cfg_q;
  lane_cmd_t cmd;
  cal_res_t  res, res_q;
  logic      busy_q, accept, ack, u_done, v_done;
  logic      out_valid_q;

  logic signed [CurW-1:0] u_cur, v_cur;
  logic signed [MvW-1:0]  u_mv, v_mv;

  logic signed [CurW-1:0] cur_u_q, cur_v_q;
  logic signed [MvW-1:0]  mv_u_q, mv_v_q;
  logic                   busy_out_q;
  logic [1:0]             status_out_q;

  assign accept     = in_valid_i & ~busy_q;
  assign ack        = u_done & v_done & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_uv <= RefUvReset;
      cfg_q.apv    <= ApvReset;
      cfg_q.n      <= NReset;
      cfg_q.delay  <= DelayReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ZERO_REF: cfg_q.ref_uv <= UvW'({10'b0, cfg_data_i[CodeW-1:0]} * UvPerMv);
        CFG_GAIN:     cfg_q.apv    <= cfg_data_i[6:0];
        CFG_SAMPLES:  cfg_q.n      <= (cfg_data_i == '0) ? NReset : cfg_data_i;
        CFG_DELAY:    cfg_q.delay  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  csoc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .action_i (action_i),
    .raw_u_i  (raw_u_i),
    .raw_v_i  (raw_v_i),
    .cfg_i    (cfg_q),
    .cmd_o    (cmd),
    .res_o    (res)
  );

  csoc_lane u_lane_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .cmd_i       (cmd),
    .code_i      (raw_u_i),
    .cfg_i       (cfg_q),
    .ack_i       (ack),
    .done_o      (u_done),
    .current_o   (u_cur),
    .offset_mv_o (u_mv)
  );

  csoc_lane u_lane_v (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .cmd_i       (cmd),
    .code_i      (raw_v_i),
    .cfg_i       (cfg_q),
    .ack_i       (ack),
    .done_o      (v_done),
    .current_o   (v_cur),
    .offset_mv_o (v_mv)
  );

  // merge stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      res_q       <= '{busy: 1'b0, status: ST_NONE};
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
        res_q  <= res;
      end else if (ack) begin
        busy_q <= 1'b0;
      end
      if (ack) begin
        out_valid_q <= 1'b1;
      end else if (~out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      cur_u_q      <= u_cur;
      cur_v_q      <= v_cur;
      mv_u_q       <= u_mv;
      mv_v_q       <= v_mv;
      busy_out_q   <= res_q.busy;
      status_out_q <= res_q.status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign current_u_ma_o = cur_u_q;
  assign current_v_ma_o = cur_v_q;
  assign offset_u_mv_o  = mv_u_q;
  assign offset_v_mv_o  = mv_v_q;
  assign cal_busy_o     = busy_out_q;
  assign cal_status_o   = status_out_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q) else $error("request accepted without going busy");

  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done == v_done) else $error("phase lanes out of step");

  a_ack_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack |=> out_valid_o) else $error("result dropped at merge");

  a_end_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ack && (res_q.status != ST_NONE)) |=> !cal_busy_o)
    else $error("calibration ended but still busy");

endmodule
